@@ rtl/core/assert_macros.svh @@
// assertion macros used by the tempo follower rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent holds in the same cycle as the consequent
`define MCTF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define MCTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MCTF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define MCTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/core/mctf_pkg.sv @@
// shared types and constants of the midi clock tempo follower
`default_nettype none

package mctf_pkg;

    // transport event codes carried in tuser
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_START    = 2'd1,
        OP_CONTINUE = 2'd2,
        OP_STOP     = 2'd3
    } t_op;

    localparam int unsigned TICKS_PER_BEAT_DEF = 24;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned BPM_W   = 16;
    localparam int unsigned CFG_W   = 9;
    localparam int unsigned OUT_W   = 56;

    // divider geometry: 32 bit numerator and divisor, 16 bit quotient
    localparam int unsigned DIV_W  = 32;
    localparam int unsigned QUO_W  = 16;
    localparam int unsigned CNT_W  = $clog2(DIV_W);

    localparam logic [BPM_W-1:0] BPM_RESET = 16'd120;
    // 60000 bpm-ms doubled, added to d for round half up
    localparam logic [DIV_W-1:0] NUM_BIAS  = 32'd120000;

endpackage

`default_nettype wire

@@ rtl/core/mctf_div.sv @@
// radix-2 restoring divider, one quotient digit per cycle
`default_nettype none

module mctf_div
    import mctf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;

    logic [DIV_W:0]   w_rem_sh;
    logic [DIV_W+1:0] w_trial;
    logic             w_fit;

    // shift the next numerator bit into the partial remainder and trial subtract
    always_comb begin
        w_rem_sh = {r_rem, r_num[DIV_W-1]};
        w_trial  = {1'b0, w_rem_sh} - {2'b00, r_den};
        w_fit    = ~w_trial[DIV_W+1];
    end

    // control: iteration counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: numerator shift register, remainder, quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_rem <= w_fit ? w_trial[DIV_W-1:0] : w_rem_sh[DIV_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

@@ rtl/core/midi_clock_tempo_follower.sv @@
// midi clock tempo follower: transport tracking, window timing and tempo confirmation
//
// Input stream: one transaction per transport event, tuser = event code (tick, start,
// continue, stop), tdata = 32 bit millisecond timestamp. Output stream: exactly one
// transaction per event carrying the tick flag, tick position, confirmed tempo,
// tempo-change flag and running flag.
// Configuration channel: a write of initial_bpm loads the confirmed tempo directly;
// it is taken only while the block is idle.
// Timing: an event that closes no measurement window passes through the exec and
// emit states into the output register. The tick that closes a window also runs the
// load, divide and judge states, with a bit-serial divider producing one quotient
// bit per cycle. One event is processed at a time; the next is accepted once the
// result of the previous one sits in the output register.
// Reset clears transport state, tick count and window, and sets the tempo to 120 bpm.
// When the receiver stalls, the result is held in the output register and a further
// event can still be accepted, whose result waits in emit until the register is free.
`default_nettype none
`include "assert_macros.svh"

module midi_clock_tempo_follower
    import mctf_pkg::*;
#(
    parameter int unsigned TICKS_PER_BEAT = TICKS_PER_BEAT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write: initial_bpm
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // event stream in
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [TIME_W-1:0] s_axis_tdata,  // [31:0] time_ms
    input  logic [1:0]        s_axis_tuser,  // [1:0] op
    // result stream out
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata   // [0] tick_advanced, [32:1] tick_position,
                                             // [48:33] tempo_bpm, [49] tempo_changed,
                                             // [50] running, [55:51] zero
);

    localparam int unsigned WIN_W = $clog2(TICKS_PER_BEAT + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_LOAD  = 6'b000100,
        S_DIV   = 6'b001000,
        S_JUDGE = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // event holding registers
    t_op                r_op;
    logic [TIME_W-1:0]  r_time;
    logic [TIME_W-1:0]  r_d;

    // follower state
    logic               r_playing;
    logic               r_downbeat;
    logic [COUNT_W-1:0] r_tick;
    logic [WIN_W-1:0]   r_win_ticks;
    logic [TIME_W-1:0]  r_win_start;
    logic [BPM_W-1:0]   r_cur_bpm;
    logic [BPM_W-1:0]   r_cand_bpm;
    logic               r_cand_valid;
    logic               r_adv;
    logic               r_chg;

    // output register
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    logic               w_in_acc;
    logic               w_cfg_acc;
    logic               w_out_free;
    logic [WIN_W-1:0]   w_win_inc;
    logic               w_win_full;
    logic [TIME_W-1:0]  w_d;
    logic               w_d_ok;
    logic               w_div_start;
    logic               w_div_done;
    logic [QUO_W-1:0]   w_quo;
    logic               w_near;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_cfg_acc     = i_cfg_valid & o_cfg_ready;
    assign w_out_free    = ~r_out_valid | m_axis_tready;

    // window bookkeeping for a counted tick
    always_comb begin
        w_win_inc  = r_win_ticks + 1'b1;
        w_win_full = (w_win_inc >= WIN_W'(TICKS_PER_BEAT));
        w_d        = r_time - r_win_start;
        w_d_ok     = (w_d != '0) & ~w_d[TIME_W-1];
    end

    // candidate lies exactly one bpm above or below the confirmed tempo
    always_comb begin
        w_near = (({1'b0, r_cur_bpm} + 17'd1) == {1'b0, w_quo})
               | (({1'b0, w_quo} + 17'd1) == {1'b0, r_cur_bpm});
    end

    // divider computes floor((120000 + d) / (2 d))
    assign w_div_start = (r_state == S_LOAD);

    mctf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_d + NUM_BIAS),
        .i_den   ({r_d[TIME_W-2:0], 1'b0}),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_EXEC;
            S_EXEC: begin
                if (r_op == OP_TICK && !r_downbeat && w_win_full && w_d_ok) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_LOAD:  n_state = S_DIV;
            S_DIV:   if (w_div_done) n_state = S_JUDGE;
            S_JUDGE: n_state = S_EMIT;
            S_EMIT:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // follower state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_playing    <= 1'b0;
            r_downbeat   <= 1'b0;
            r_tick       <= '0;
            r_win_ticks  <= '0;
            r_win_start  <= '0;
            r_cur_bpm    <= BPM_RESET;
            r_cand_bpm   <= '0;
            r_cand_valid <= 1'b0;
            r_adv        <= 1'b0;
            r_chg        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_acc) begin
                r_cur_bpm <= BPM_W'(i_cfg_data);
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_adv <= 1'b0;
                        r_chg <= 1'b0;
                    end
                end
                S_EXEC: begin
                    case (r_op)
                        OP_TICK: begin
                            if (r_downbeat) begin
                                // first tick after start or continue opens the window
                                r_downbeat  <= 1'b0;
                                r_win_start <= r_time;
                                r_win_ticks <= '0;
                            end else begin
                                r_adv  <= 1'b1;
                                r_tick <= r_tick + 1'b1;
                                if (w_win_full) begin
                                    r_win_ticks <= '0;
                                    r_win_start <= r_time;
                                    if (!w_d_ok) begin
                                        r_cand_valid <= 1'b0;
                                    end
                                end else begin
                                    r_win_ticks <= w_win_inc;
                                end
                            end
                        end
                        OP_START, OP_CONTINUE: begin
                            r_playing    <= 1'b1;
                            r_downbeat   <= 1'b1;
                            r_win_start  <= r_time;
                            r_win_ticks  <= '0;
                            r_cand_valid <= 1'b0;
                            if (r_op == OP_START) begin
                                r_tick <= '0;
                            end
                        end
                        OP_STOP: r_playing <= 1'b0;
                        default: r_playing <= r_playing;
                    endcase
                end
                S_JUDGE: begin
                    // two agreeing windows needed to move by more than one bpm
                    if (w_quo == '0 || w_quo == r_cur_bpm || w_near) begin
                        r_cand_valid <= 1'b0;
                    end else if (r_cand_valid && r_cand_bpm == w_quo) begin
                        r_cur_bpm    <= w_quo;
                        r_cand_valid <= 1'b0;
                        r_chg        <= 1'b1;
                    end else begin
                        r_cand_bpm   <= w_quo;
                        r_cand_valid <= 1'b1;
                    end
                end
                default: r_adv <= r_adv;
            endcase
        end
    end

    // event and window length capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op   <= t_op'(s_axis_tuser);
            r_time <= s_axis_tdata;
        end
        if (r_state == S_EXEC) begin
            r_d <= w_d;
        end
    end

    // output register handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_out_free) begin
            r_out_data <= {5'd0, r_playing, r_chg, r_cur_bpm, r_tick, r_adv};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // checks
    `MCTF_ASSERT_SAME(a_done_in_div, i_clk, i_rst_n, w_div_done, r_state == S_DIV,
        "divider finished outside the divide state")
    `MCTF_ASSERT_SAME(a_chg_implies_adv, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[49],
        m_axis_tdata[0], "tempo change reported on an event that was not a counted tick")
    `MCTF_ASSERT_NEXT(a_cfg_loads_bpm, i_clk, i_rst_n, w_cfg_acc,
        r_cur_bpm == BPM_W'($past(i_cfg_data)), "configuration write did not load the tempo")
    `MCTF_ASSERT_NEXT(a_emit_fills_out, i_clk, i_rst_n, r_state == S_EMIT && w_out_free,
        r_out_valid, "result was not registered on emit")

endmodule

`default_nettype wire
